// File: sv/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Types and constants shared by the Go-Back-N sender modules.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int SEQ_W     = 31;
  localparam int TMO_W     = 24;
  localparam int WIN_W     = 6;
  localparam int ACK_W     = 32;
  localparam int ALU_W     = 33;
  localparam int IDX_W     = 2;
  localparam int DATA_W    = 31;
  localparam int MAX_BURST = 32;

  localparam logic [TMO_W-1:0] ELAPSED_MAX = '1;

  localparam logic [SEQ_W-1:0] TOTAL_RST   = 31'd100000;
  localparam logic [TMO_W-1:0] TIMEOUT_RST = 24'd50000;
  localparam logic [WIN_W-1:0] WINDOW_RST  = 6'd32;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_ACK  = 1'b1;

  typedef enum logic [IDX_W-1:0] {
    REG_TOTAL   = 2'd0,
    REG_TIMEOUT = 2'd1,
    REG_WINDOW  = 2'd2
  } reg_idx_t;

  // win is the effective window, already clamped to 1..MAX_BURST
  typedef struct packed {
    logic [SEQ_W-1:0] total;
    logic [TMO_W-1:0] timeout;
    logic [WIN_W-1:0] win;
  } cfg_t;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

endpackage

// File: sv/gbn_if.sv
// ----------------------------------------------------------------------------
// gbn_if
// Valid/ready channels of the Go-Back-N sender: input items and send beats.
// ----------------------------------------------------------------------------
interface gbn_in_if;
  import gbn_pkg::*;

  logic             valid;
  logic             ready;
  logic             command;
  logic [ACK_W-1:0] ack_number;

  modport source (output valid, command, ack_number, input ready);
  modport sink   (input valid, command, ack_number, output ready);
endinterface

interface gbn_out_if;
  import gbn_pkg::*;

  logic             valid;
  logic             ready;
  logic [SEQ_W-1:0] seq_number;
  logic             is_resend;
  logic             last_of_run;
  logic             all_delivered;

  modport source (output valid, seq_number, is_resend, last_of_run, all_delivered,
                  input ready);
  modport sink   (input valid, seq_number, is_resend, last_of_run, all_delivered,
                  output ready);
endinterface

// File: sv/gbn_alu.sv
// ----------------------------------------------------------------------------
// gbn_alu
// Shared 33-bit subtractor; sign of the difference serves as the compare.
// ----------------------------------------------------------------------------
module gbn_alu (
  input  gbn_pkg::alu_req_t           req,
  output logic [gbn_pkg::ALU_W-1:0]   diff
);
  import gbn_pkg::*;

  assign diff = req.a - req.b;

endmodule

// File: sv/gbn_ctrl.sv
// ----------------------------------------------------------------------------
// gbn_ctrl
// Sequencer of the Go-Back-N sender: window and timer state, the compare
// steps run through the shared subtractor, and the send beat register.
// ----------------------------------------------------------------------------
module gbn_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  gbn_pkg::cfg_t               cfg,
  gbn_in_if.sink                      items,
  gbn_out_if.source                   sends,
  output gbn_pkg::alu_req_t           alu_req,
  input  logic [gbn_pkg::ALU_W-1:0]   alu_d
);
  import gbn_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACK_LO,
    S_ACK_HI,
    S_ACK_INC,
    S_TICK_INC,
    S_TICK_CMP,
    S_OUTST,
    S_AVAIL,
    S_DONE,
    S_EMIT_RS,
    S_FR_LOAD,
    S_EMIT_FR
  } state_t;

  state_t           state;
  logic [ACK_W-1:0] ack;
  logic [SEQ_W-1:0] base;
  logic [SEQ_W-1:0] next_seq;
  logic             running;
  logic [TMO_W-1:0] elapsed;
  logic             resend;
  logic             ge_base;
  logic [WIN_W-1:0] outst;
  logic [WIN_W-1:0] fresh;
  logic [WIN_W-1:0] rs_left;
  logic [WIN_W-1:0] remain;
  logic             done;
  logic [SEQ_W-1:0] seq;

  logic             ovalid;
  logic [SEQ_W-1:0] oseq;
  logic             oresend;
  logic             olast;
  logic             odone;

  logic             neg;
  logic             slot_free;
  logic             load;
  logic [WIN_W-1:0] room;
  logic [WIN_W-1:0] rs_cnt;
  logic [WIN_W-1:0] run_len;

  assign neg       = alu_d[ALU_W-1];
  assign slot_free = !ovalid || sends.ready;
  assign load      = ((state == S_EMIT_RS) || (state == S_EMIT_FR)) && slot_free;
  assign room      = (cfg.win > outst) ? (cfg.win - outst) : '0;
  assign rs_cnt    = resend ? outst : '0;
  assign run_len   = rs_cnt + fresh;

  assign items.ready         = (state == S_IDLE);
  assign sends.valid         = ovalid;
  assign sends.seq_number    = oseq;
  assign sends.is_resend     = oresend;
  assign sends.last_of_run   = olast;
  assign sends.all_delivered = odone;

  // operand select for the shared subtractor
  always_comb begin
    alu_req.a = '0;
    alu_req.b = '0;
    case (state)
      S_ACK_LO: begin
        alu_req.a = {ack[ACK_W-1], ack};
        alu_req.b = {2'b00, base};
      end
      S_ACK_HI: begin
        alu_req.a = {ack[ACK_W-1], ack};
        alu_req.b = {2'b00, next_seq};
      end
      S_ACK_INC: begin
        alu_req.a = {ack[ACK_W-1], ack};
        alu_req.b = '1;
      end
      S_TICK_CMP: begin
        alu_req.a = {{(ALU_W-TMO_W){1'b0}}, cfg.timeout};
        alu_req.b = {{(ALU_W-TMO_W){1'b0}}, elapsed};
      end
      S_OUTST: begin
        alu_req.a = {2'b00, next_seq};
        alu_req.b = {2'b00, base};
      end
      S_AVAIL: begin
        alu_req.a = {2'b00, cfg.total};
        alu_req.b = {2'b00, next_seq};
      end
      S_DONE: begin
        alu_req.a = {2'b00, base};
        alu_req.b = {2'b00, cfg.total};
      end
      S_EMIT_RS, S_EMIT_FR: begin
        alu_req.a = {2'b00, seq};
        alu_req.b = '1;
      end
      default: begin
        alu_req.a = '0;
        alu_req.b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      base     <= '0;
      next_seq <= '0;
      running  <= 1'b0;
      elapsed  <= '0;
      resend   <= 1'b0;
      ovalid   <= 1'b0;
    end else begin
      if (load) begin
        ovalid <= 1'b1;
      end else if (ovalid && sends.ready) begin
        ovalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (items.valid) begin
            ack    <= items.ack_number;
            resend <= 1'b0;
            state  <= (items.command == CMD_ACK) ? S_ACK_LO : S_TICK_INC;
          end
        end
        S_ACK_LO: begin
          ge_base <= !neg;
          state   <= S_ACK_HI;
        end
        S_ACK_HI: begin
          // ack inside [base, next_seq): running unless ack+1 reaches next_seq
          if (ge_base && neg) begin
            running <= (alu_d != '1);
            elapsed <= '0;
            state   <= S_ACK_INC;
          end else begin
            state <= S_OUTST;
          end
        end
        S_ACK_INC: begin
          base  <= alu_d[SEQ_W-1:0];
          state <= S_OUTST;
        end
        S_TICK_INC: begin
          if (running) begin
            if (elapsed != ELAPSED_MAX) begin
              elapsed <= elapsed + 1'b1;
            end
            state <= S_TICK_CMP;
          end else begin
            state <= S_OUTST;
          end
        end
        S_TICK_CMP: begin
          // timeout - elapsed < 0: fire
          if (neg) begin
            resend  <= 1'b1;
            elapsed <= '0;
          end
          state <= S_OUTST;
        end
        S_OUTST: begin
          outst <= alu_d[WIN_W-1:0];
          state <= S_AVAIL;
        end
        S_AVAIL: begin
          if (neg) begin
            fresh <= '0;
          end else if ((alu_d[ALU_W-2:WIN_W] != '0) || (alu_d[WIN_W-1:0] >= room)) begin
            fresh <= room;
          end else begin
            fresh <= alu_d[WIN_W-1:0];
          end
          state <= S_DONE;
        end
        S_DONE: begin
          done    <= !neg;
          rs_left <= rs_cnt;
          remain  <= run_len;
          seq     <= (rs_cnt != '0) ? base : next_seq;
          // first fresh send from an empty window starts the timer
          if ((fresh != '0) && (outst == '0)) begin
            running <= 1'b1;
            elapsed <= '0;
          end
          if (run_len == '0) begin
            state <= S_IDLE;
          end else if (rs_cnt != '0) begin
            state <= S_EMIT_RS;
          end else begin
            state <= S_EMIT_FR;
          end
        end
        S_EMIT_RS: begin
          if (slot_free) begin
            oseq    <= seq;
            oresend <= 1'b1;
            olast   <= (remain == WIN_W'(1));
            odone   <= done;
            seq     <= alu_d[SEQ_W-1:0];
            rs_left <= rs_left - 1'b1;
            remain  <= remain - 1'b1;
            if (remain == WIN_W'(1)) begin
              state <= S_IDLE;
            end else if (rs_left == WIN_W'(1)) begin
              state <= S_FR_LOAD;
            end
          end
        end
        S_FR_LOAD: begin
          seq   <= next_seq;
          state <= S_EMIT_FR;
        end
        S_EMIT_FR: begin
          if (slot_free) begin
            oseq     <= seq;
            oresend  <= 1'b0;
            olast    <= (remain == WIN_W'(1));
            odone    <= done;
            seq      <= alu_d[SEQ_W-1:0];
            next_seq <= alu_d[SEQ_W-1:0];
            remain   <= remain - 1'b1;
            if (remain == WIN_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/go_back_n_sender.sv
// ----------------------------------------------------------------------------
// go_back_n_sender
// Go-Back-N sequence-number core: window base, next sequence number and
// retransmission timer, driven by tick and acknowledgement items.
// ----------------------------------------------------------------------------
// Usage:
//   items : one beat per input item; command 0 is a time tick, 1 carries a
//           cumulative ack in ack_number.
//   sends : one beat per sequence number to transmit; a timeout resend of the
//           outstanding range comes first (is_resend set), then fresh numbers.
//           last_of_run marks the final beat caused by an item.
//   wr_en/wr_index/wr_data : register writes (total, timeout, window), only
//           while no item is in flight.
// Timing: after an item is taken, the compare steps run through the one
//   shared subtractor, then one beat is loaded per cycle while sends is not
//   stalled, with the FR_LOAD step between a resend run and a fresh run.
//   items.ready returns once the last beat sits in the output register; an
//   item causes at most 32 beats.
// Reset: window base, next sequence number and timer clear; the registers
//   take their defaults (100000 packets, 50000 ticks, window 32).
// A stall on sends holds the beat register, and the sequencer in its emit states.
// ----------------------------------------------------------------------------
module go_back_n_sender #(
  parameter int WINDOW = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  gbn_in_if.sink                       items,
  gbn_out_if.source                    sends,
  input  logic                         wr_en,
  input  logic [gbn_pkg::IDX_W-1:0]    wr_index,
  input  logic [gbn_pkg::DATA_W-1:0]   wr_data
);
  import gbn_pkg::*;

  localparam int WIN_CAP = (WINDOW < MAX_BURST) ? WINDOW : MAX_BURST;

  logic [SEQ_W-1:0] total_packets;
  logic [TMO_W-1:0] timeout_ticks;
  logic [WIN_W-1:0] window_in_use;

  cfg_t             cfg;
  alu_req_t         alu_req;
  logic [ALU_W-1:0] alu_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_packets <= TOTAL_RST;
      timeout_ticks <= TIMEOUT_RST;
      window_in_use <= WINDOW_RST;
    end else if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_TOTAL:   total_packets <= wr_data[SEQ_W-1:0];
        REG_TIMEOUT: timeout_ticks <= wr_data[TMO_W-1:0];
        REG_WINDOW:  window_in_use <= wr_data[WIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // zero window acts as one; cap at the parameter and the burst limit
  always_comb begin
    cfg.total   = total_packets;
    cfg.timeout = timeout_ticks;
    if (window_in_use == '0) begin
      cfg.win = WIN_W'(1);
    end else if (window_in_use > WIN_W'(WIN_CAP)) begin
      cfg.win = WIN_W'(WIN_CAP);
    end else begin
      cfg.win = window_in_use;
    end
  end

  gbn_alu u_alu (
    .req  (alu_req),
    .diff (alu_d)
  );

  gbn_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .items   (items),
    .sends   (sends),
    .alu_req (alu_req),
    .alu_d   (alu_d)
  );

`ifndef SYNTHESIS
  // an accepted item keeps the sequencer busy in the next cycle
  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    items.valid && items.ready |=> !items.ready)
    else $error("ready stayed high after an item was taken");

  // a beat still waiting while idle must close its run
  a_idle_beat_last: assert property (@(posedge clk) disable iff (rst)
    items.ready && sends.valid |-> sends.last_of_run)
    else $error("pending beat without last_of_run while idle");

  // a resend beat never follows an unfinished fresh beat of the same run
  a_resend_order: assert property (@(posedge clk) disable iff (rst)
    sends.valid && sends.ready && !sends.is_resend && !sends.last_of_run
      |=> !(sends.valid && sends.is_resend))
    else $error("resend beat after a fresh beat in one run");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !sends.valid && items.ready)
    else $error("sender not quiet after reset");
`endif

endmodule

// File: verif/gbn_send_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gbn_send_checker
// Tracks the sender state from the accepted items and register writes,
// works out the send beats that every item causes and compares the beats
// on the send channel against them in order.
// ----------------------------------------------------------------------------
module gbn_send_checker #(
  parameter int WINDOW = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  gbn_in_if                          items,
  gbn_out_if                         sends,
  input  logic                       wr_en,
  input  logic [gbn_pkg::IDX_W-1:0]  wr_index,
  input  logic [gbn_pkg::DATA_W-1:0] wr_data,
  output int                         beats_pending,
  output int                         fail_count
);
  import gbn_pkg::*;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic             resend;
    logic             last;
    logic             done;
  } send_beat_t;

  logic [SEQ_W-1:0] total_pkts;
  logic [TMO_W-1:0] timeout;
  logic [WIN_W-1:0] win_reg;
  logic [SEQ_W-1:0] base;
  logic [SEQ_W-1:0] next_seq;
  logic             timer_on;
  logic [TMO_W-1:0] elapsed;
  send_beat_t       beats_due[$];
  int               errors = 0;

  assign fail_count = errors;

  task automatic report(string line);
    errors++;
    if (errors <= 100) begin
      $display("%0t mismatch: %s", $time, line);
    end
  endtask

  function automatic void predict_sends(logic cmd, logic [ACK_W-1:0] ack);
    send_beat_t       run[$];
    send_beat_t       b;
    longint           ack_val;
    int               win;
    logic             done;
    logic [SEQ_W-1:0] s;
    win = (win_reg == '0) ? 1 : int'(win_reg);
    if (win > WINDOW) win = WINDOW;
    if (win > MAX_BURST) win = MAX_BURST;
    if (cmd == CMD_ACK) begin
      ack_val = longint'($signed(ack));
      // only an ack inside the outstanding range slides the base
      if (ack_val >= longint'(base) && ack_val < longint'(next_seq)) begin
        base     = ack[SEQ_W-1:0] + 1'b1;
        elapsed  = '0;
        timer_on = (base != next_seq);
      end
    end else if (timer_on) begin
      if (elapsed != ELAPSED_MAX) elapsed++;
      if (elapsed > timeout) begin
        for (s = base; s < next_seq && run.size() < MAX_BURST; s++) begin
          b = '{s, 1'b1, 1'b0, 1'b0};
          run.push_back(b);
        end
        elapsed = '0;
      end
    end
    while (longint'(next_seq) < longint'(base) + win && next_seq < total_pkts &&
           run.size() < MAX_BURST) begin
      b = '{next_seq, 1'b0, 1'b0, 1'b0};
      run.push_back(b);
      // first packet of an empty window starts the timer
      if (base == next_seq) begin
        timer_on = 1'b1;
        elapsed  = '0;
      end
      next_seq++;
    end
    done = (base >= total_pkts);
    foreach (run[i]) begin
      b      = run[i];
      b.done = done;
      b.last = (i == run.size() - 1);
      beats_due.push_back(b);
    end
  endfunction

  always @(posedge clk) begin
    send_beat_t want;
    if (rst) begin
      total_pkts = TOTAL_RST;
      timeout    = TIMEOUT_RST;
      win_reg    = WINDOW_RST;
      base       = '0;
      next_seq   = '0;
      timer_on   = 1'b0;
      elapsed    = '0;
      beats_due.delete();
    end else begin
      if (sends.valid && sends.ready) begin
        if (beats_due.size() == 0) begin
          report($sformatf("unexpected beat, seq_number %0d", sends.seq_number));
        end else begin
          want = beats_due.pop_front();
          if (sends.seq_number !== want.seq)
            report($sformatf("seq_number %0d, expected %0d", sends.seq_number, want.seq));
          if (sends.is_resend !== want.resend)
            report($sformatf("is_resend %b on seq %0d", sends.is_resend, want.seq));
          if (sends.last_of_run !== want.last)
            report($sformatf("last_of_run %b on seq %0d", sends.last_of_run, want.seq));
          if (sends.all_delivered !== want.done)
            report($sformatf("all_delivered %b on seq %0d", sends.all_delivered, want.seq));
        end
      end
      if (wr_en) begin
        case (wr_index)
          REG_TOTAL:   total_pkts = wr_data[SEQ_W-1:0];
          REG_TIMEOUT: timeout    = wr_data[TMO_W-1:0];
          REG_WINDOW:  win_reg    = wr_data[WIN_W-1:0];
          default: ;
        endcase
      end
      if (items.valid && items.ready) begin
        predict_sends(items.command, items.ack_number);
      end
    end
    beats_pending <= beats_due.size();
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives ticks and acks into the Go-Back-N sender under several register
// settings, with random gaps and back-pressure; the checker beside the block
// predicts and compares every send beat.
// ----------------------------------------------------------------------------
module tb_top;
  import gbn_pkg::*;

  localparam int WINDOW         = 32;
  localparam int PHASE_ITEMS    = 26;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 48;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [DATA_W-1:0] TOTAL_MAX = '1;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              wr_en    = 1'b0;
  logic [IDX_W-1:0]  wr_index = '0;
  logic [DATA_W-1:0] wr_data  = '0;

  int     beats_pending;
  int     fail_count;
  int     idle_pct   = 33;
  int     hold_left  = 0;
  int     hold_reqs  = 0;
  int     hold_seen  = 0;
  int     quiet      = 0;
  longint acked_upto = 0;
  longint sent_upto  = 0;

  gbn_in_if  items_ch ();
  gbn_out_if sends_ch ();

  go_back_n_sender #(
    .WINDOW (WINDOW)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .items    (items_ch),
    .sends    (sends_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  gbn_send_checker #(
    .WINDOW (WINDOW)
  ) i_checker (
    .clk           (clk),
    .rst           (rst),
    .items         (items_ch),
    .sends         (sends_ch),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .beats_pending (beats_pending),
    .fail_count    (fail_count)
  );

  always #4 clk = ~clk;

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      sends_ch.ready <= 1'b0;
    end else begin
      sends_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // one past the highest fresh sequence number seen so far, for building valid acks
  always @(posedge clk) begin
    if (sends_ch.valid && sends_ch.ready && !sends_ch.is_resend &&
        longint'(sends_ch.seq_number) >= sent_upto) begin
      sent_upto <= longint'(sends_ch.seq_number) + 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (items_ch.valid && items_ch.ready) || (sends_ch.valid && sends_ch.ready)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("FAIL go_back_n_sender");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_item(logic cmd, logic [ACK_W-1:0] ack);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      items_ch.valid <= 1'b0;
      @(negedge clk);
    end
    items_ch.valid      <= 1'b1;
    items_ch.command    <= cmd;
    items_ch.ack_number <= ack;
    do @(posedge clk); while (!items_ch.ready);
  endtask

  task automatic configure(logic [DATA_W-1:0] total, logic [DATA_W-1:0] timeout,
                           logic [DATA_W-1:0] window);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= REG_TOTAL;
    wr_data  <= total;
    @(negedge clk);
    wr_index <= REG_TIMEOUT;
    wr_data  <= timeout;
    @(negedge clk);
    wr_index <= REG_WINDOW;
    wr_data  <= window;
    @(negedge clk);
    wr_en    <= 1'b0;
  endtask

  // drop valid, wait for every predicted beat, then let the block go idle
  task automatic drain();
    @(negedge clk) items_ch.valid <= 1'b0;
    wait (beats_pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_item();
    int unsigned      pick;
    longint           span;
    logic [ACK_W-1:0] ack;
    pick = $urandom_range(0, 99);
    span = sent_upto - acked_upto;
    if (pick < 45) begin
      send_item(CMD_TICK, $urandom());
    end else if (pick < 88 && span > 0) begin
      ack        = ACK_W'(acked_upto + $urandom_range(0, int'(span) - 1));
      acked_upto = longint'(ack) + 1;
      send_item(CMD_ACK, ack);
    end else begin
      case ($urandom_range(0, 2))
        0:       ack = $urandom();
        1:       ack = ACK_W'(acked_upto - 1 - $urandom_range(0, 3));
        default: ack = ACK_W'(sent_upto + 100 + $urandom_range(0, 1000));
      endcase
      send_item(CMD_ACK, ack);
    end
  endtask

  task automatic run_phase(logic [DATA_W-1:0] total, logic [DATA_W-1:0] timeout,
                           logic [DATA_W-1:0] window, int idle, bit squeeze);
    configure(total, timeout, window);
    idle_pct = idle;
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      if (squeeze && k == 4) hold_reqs++;
      random_item();
    end
    drain();
  endtask

  initial begin
    items_ch.valid      = 1'b0;
    items_ch.command    = CMD_TICK;
    items_ch.ack_number = '0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // small window: stale, negative and future acks, timeout resend, completion
    configure(31'd10, 31'd1, 31'd4);
    send_item(CMD_TICK, '0);
    send_item(CMD_ACK, 32'hFFFF_FFFF);
    send_item(CMD_ACK, 32'h7FFF_FFFF);
    send_item(CMD_ACK, 32'd4);
    send_item(CMD_TICK, '0);
    send_item(CMD_TICK, '0);
    send_item(CMD_ACK, 32'd1);
    send_item(CMD_ACK, 32'd1);
    send_item(CMD_ACK, 32'd5);
    send_item(CMD_TICK, '0);
    send_item(CMD_TICK, '0);
    send_item(CMD_ACK, 32'd9);
    send_item(CMD_TICK, '0);
    send_item(CMD_ACK, 32'h8000_0000);
    drain();

    // zero total, zero window
    configure(31'd0, 31'd0, 31'd0);
    send_item(CMD_TICK, '1);
    send_item(CMD_ACK, 32'd0);
    drain();

    // oversized window register, zero timeout: full bursts both ways
    configure(TOTAL_MAX, 31'd0, 31'd63);
    send_item(CMD_TICK, '0);
    send_item(CMD_TICK, '0);
    send_item(CMD_ACK, 32'd41);
    drain();

    // total lowered below next sequence; upper data bits ignored by the timeout
    configure(31'd20, 31'h7F00_0002, 31'd32);
    send_item(CMD_ACK, 32'd50);
    send_item(CMD_TICK, '0);
    send_item(CMD_TICK, '0);
    send_item(CMD_TICK, '0);
    send_item(CMD_ACK, 32'd73);
    drain();
    acked_upto = 74;

    run_phase(TOTAL_MAX, 31'd3, 31'd1, 33, 1'b0);
    run_phase(TOTAL_MAX, 31'd0, 31'd32, 33, 1'b0);
    run_phase(TOTAL_MAX, 31'd5, 31'd7, 0, 1'b0);
    run_phase(TOTAL_MAX, 31'd2, 31'd16, 33, 1'b1);
    run_phase(TOTAL_MAX, 31'hFF_FFFF, 31'd63, 33, 1'b0);
    run_phase(31'd1, 31'd1, 31'd32, 33, 1'b0);

    if (fail_count == 0) begin
      $display("PASS go_back_n_sender");
    end else begin
      $display("FAIL go_back_n_sender");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/gbn_pkg.sv
sv/gbn_if.sv
sv/gbn_alu.sv
sv/gbn_ctrl.sv
sv/go_back_n_sender.sv
verif/gbn_send_checker.sv
verif/tb_top.sv
